// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// shared constants for the strongly connected component search
// ----------------------------------------------------------------------------
package scc_pkg;
    localparam int unsigned MAX_NODES = 64;
    localparam int unsigned NODE_W    = 6;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned ROW_W     = 64;
endpackage

// ===== rtl/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components
// Tarjan component search over a loaded successor-row graph
// ----------------------------------------------------------------------------
// Rows arrive on the input channel (i_valid/o_in_ready), one word per cycle
// while the block is idle. A word with last_row set is stored and then starts
// the search over nodes 0 to node_count-1; o_in_ready stays low until the
// search has finished and its final component word has left.
// Each component leaves as one word on the output channel (o_valid/
// i_out_ready), the final one with o_last_component set. A small sequencer
// drives one adjacency read port and a successor scan that tests one bit per
// cycle, except that a successor found on the stack holds the scan while its
// order is read. Component words leave one behind the search so the last
// can be flagged; when the receiver stalls, one word waits in the output
// register, one in a holding register, and the sequencer waits at the next
// component. node_count must be written through i_cfg_we / i_cfg_data only
// while idle; the block does not enforce this. The count a search uses
// saturates to MAX_NODES. Synchronous active-low reset returns the block to
// idle with node_count = 64; the memories need no clearing.
// ----------------------------------------------------------------------------
module strongly_connected_components
    import scc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_in_ready,
    input  logic [NODE_W-1:0]    i_node_index,
    input  logic [ROW_W-1:0]     i_successor_mask,
    input  logic                 i_last_row,
    output logic                 o_valid,
    input  logic                 i_out_ready,
    output logic [ROW_W-1:0]     o_component_mask,
    output logic                 o_last_component
);
    localparam logic [3:0] S_IDLE = 4'd0, S_ROOT = 4'd1, S_ENTER = 4'd2,
        S_FRAME = 4'd3, S_SCAN = 4'd4, S_RET = 4'd5, S_POP = 4'd6,
        S_EMIT = 4'd7, S_PARENT = 4'd8, S_FLUSH = 4'd9;

    logic [3:0]           r_state;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   r_n;
    logic [ROW_W-1:0]     adj_mem [MAX_NODES];
    logic [NODE_W-1:0]    ord_mem [MAX_NODES];
    logic [NODE_W-1:0]    low_mem [MAX_NODES];
    logic [NODE_W-1:0]    stk_mem [MAX_NODES];
    logic [NODE_W+COUNT_W-1:0] frm_mem [MAX_NODES];
    logic [ROW_W-1:0]     r_visited, r_onstk, r_members;
    logic [COUNT_W-1:0]   r_vnum, r_sdep, r_fdep, r_root, r_j;
    logic [NODE_W-1:0]    r_v, r_vlow, r_vord, r_w;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     r_hold;
    logic                 r_have;
    logic [ROW_W-1:0]     r_out;
    logic                 r_ovalid, r_olast;

    logic [NODE_W-1:0] w_j6, w_r6, w_sidx, w_fidx;
    assign w_j6   = r_j[NODE_W-1:0];
    assign w_r6   = r_root[NODE_W-1:0];
    assign w_sidx = r_sdep[NODE_W-1:0] - NODE_W'(1);
    assign w_fidx = r_fdep[NODE_W-1:0] - NODE_W'(1);

    assign o_in_ready       = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid          = r_ovalid;
    assign o_component_mask = r_out;
    assign o_last_component = r_olast;

    logic acc;
    assign acc = i_valid && o_in_ready;

    // registered reads
    logic [ROW_W-1:0]  r_rd_adj;
    logic [NODE_W-1:0] r_rd_ord, r_rd_low, r_rd_stk, r_rd_lowp;
    logic [NODE_W+COUNT_W-1:0] r_rd_frm;
    logic [NODE_W-1:0] r_raddr_v, r_raddr_w;

    always_ff @(posedge i_clk) begin
        if (acc)
            adj_mem[i_node_index] <= i_successor_mask;
        r_rd_adj <= adj_mem[r_raddr_v];
        r_rd_ord <= ord_mem[r_raddr_w];
        r_rd_low <= low_mem[r_raddr_v];
        r_rd_lowp <= low_mem[r_raddr_w];
        r_rd_stk <= stk_mem[w_sidx];
        r_rd_frm <= frm_mem[w_fidx];
    end

    logic [ROW_W-1:0] live;
    always_comb begin
        live = '0;
        for (int k = 0; k < ROW_W; k++)
            live[k] = (COUNT_W'(k) < r_n);
    end

    logic succ_bit;
    assign succ_bit = r_row[w_j6] & live[w_j6];

    // sub-step counter for memory latency
    logic [1:0] r_ph;

    logic w_load_out;
    assign w_load_out = r_have && (!r_ovalid || i_out_ready)
                        && (r_state == S_EMIT || r_state == S_FLUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= COUNT_W'(64);
            r_ovalid <= 1'b0;
            r_olast <= 1'b0;
            r_ph <= '0;
            r_have <= 1'b0;
        end else begin
            if (w_load_out) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) r_count <= i_cfg_data;
            unique case (r_state)
                S_IDLE: if (acc && i_last_row) begin
                    r_n <= (32'(r_count) > MAX_NODES) ? COUNT_W'(MAX_NODES) : r_count;
                    r_visited <= '0; r_onstk <= '0; r_vnum <= '0;
                    r_sdep <= '0; r_fdep <= '0; r_root <= '0;
                    r_have <= 1'b0; r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_root >= r_n) r_state <= S_FLUSH;
                    else if (r_visited[w_r6]) r_root <= r_root + COUNT_W'(1);
                    else begin r_w <= w_r6; r_state <= S_ENTER; end
                end
                S_ENTER: begin
                    ord_mem[r_w] <= r_vnum[NODE_W-1:0];
                    low_mem[r_w] <= r_vnum[NODE_W-1:0];
                    r_vnum <= r_vnum + COUNT_W'(1);
                    r_visited[r_w] <= 1'b1;
                    r_onstk[r_w] <= 1'b1;
                    stk_mem[r_sdep[NODE_W-1:0]] <= r_w;
                    r_sdep <= r_sdep + COUNT_W'(1);
                    frm_mem[r_fdep[NODE_W-1:0]] <= {COUNT_W'(0), r_w};
                    r_fdep <= r_fdep + COUNT_W'(1);
                    r_ph <= '0;
                    r_state <= S_FRAME;
                end
                S_FRAME: begin
                    // fetch top frame, then its row, low and order
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd1) begin
                        r_v <= r_rd_frm[NODE_W-1:0];
                        r_j <= r_rd_frm[NODE_W+COUNT_W-1:NODE_W];
                        r_raddr_v <= r_rd_frm[NODE_W-1:0];
                        r_raddr_w <= r_rd_frm[NODE_W-1:0];
                    end
                    if (r_ph == 2'd3) begin
                        r_row <= r_rd_adj; r_vlow <= r_rd_low; r_vord <= r_rd_ord;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_ph == 2'd0) begin
                        if (r_j >= r_n) begin
                            low_mem[r_v] <= r_vlow;
                            r_fdep <= r_fdep - COUNT_W'(1);
                            r_state <= S_RET;
                        end else if (!succ_bit) r_j <= r_j + COUNT_W'(1);
                        else if (!r_visited[w_j6]) begin
                            low_mem[r_v] <= r_vlow;
                            frm_mem[w_fidx] <= {r_j + COUNT_W'(1), r_v};
                            r_w <= w_j6; r_state <= S_ENTER;
                        end else if (r_onstk[w_j6]) begin
                            r_raddr_w <= w_j6; r_ph <= 2'd1;
                        end else r_j <= r_j + COUNT_W'(1);
                    end else if (r_ph == 2'd1) r_ph <= 2'd2;
                    else begin
                        if (r_rd_ord < r_vlow) r_vlow <= r_rd_ord;
                        r_j <= r_j + COUNT_W'(1); r_ph <= 2'd0;
                    end
                end
                S_RET: begin
                    r_members <= '0; r_ph <= '0;
                    r_state <= (r_vlow == r_vord) ? S_POP : S_PARENT;
                end
                S_POP: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else begin
                        r_members[r_rd_stk] <= 1'b1;
                        r_onstk[r_rd_stk] <= 1'b0;
                        r_sdep <= r_sdep - COUNT_W'(1);
                        r_ph <= 2'd0;
                        if (r_rd_stk == r_v || r_sdep == COUNT_W'(1)) r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_have || w_load_out) begin
                        if (r_have) begin
                            r_out <= r_hold; r_olast <= 1'b0;
                        end
                        r_hold <= r_members; r_have <= 1'b1; r_ph <= '0;
                        r_state <= S_PARENT;
                    end
                end
                S_PARENT: begin
                    if (r_fdep == '0) begin
                        r_root <= r_root + COUNT_W'(1); r_state <= S_ROOT;
                    end else begin
                        r_ph <= r_ph + 2'd1;
                        if (r_ph == 2'd1) r_raddr_w <= r_rd_frm[NODE_W-1:0];
                        if (r_ph == 2'd3) begin
                            if (r_vlow < r_rd_lowp) low_mem[r_raddr_w] <= r_vlow;
                            r_state <= S_FRAME;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_have) r_state <= S_IDLE;
                    else if (w_load_out) begin
                        r_out <= r_hold; r_olast <= 1'b1;
                        r_have <= 1'b0; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/scc_checker.sv =====
// ----------------------------------------------------------------------------
// scc_checker
// port-level checks for the component search
// ----------------------------------------------------------------------------
module scc_checker
    import scc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_valid,
    input logic             i_out_ready,
    input logic [ROW_W-1:0] o_component_mask,
    input logic             o_last_component
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_out_ready |=> o_valid && $stable(o_component_mask)
            && $stable(o_last_component))
        else $error("output word changed under stall");
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_component_mask != '0)
        else $error("empty component");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_in_ready)
        else $error("input taken while output pending");
endmodule

bind strongly_connected_components scc_checker u_scc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready), .o_valid(o_valid),
    .i_out_ready(i_out_ready), .o_component_mask(o_component_mask),
    .o_last_component(o_last_component)
);
